@@ hw/rtl/fbfl_pkg.sv @@
// Shared types and constants for the fixed-block free-list allocator.
// Used by fbfl_ctrl and fixed_block_free_list_allocator_top; no dependencies.
package fbfl_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths.
  localparam int NUM_W   = 11;
  localparam int BYTES_W = 17;
  localparam int OFF_W   = 26;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  typedef logic [LINK_W-1:0] link_t;

  // Link value that marks the end of the list.
  localparam link_t NIL_LINK = link_t'(MAX_BLOCKS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Register select codes (address bit 2).
  localparam logic REG_NUM_BLOCKS  = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  typedef struct packed {
    logic [NUM_W-1:0]   num_blocks;
    logic [BYTES_W-1:0] block_bytes;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   block_index;
    logic [OFF_W-1:0]   block_offset;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] free_count;
  } result_t;

endpackage

@@ hw/rtl/fixed_block_free_list_allocator_top.sv @@
// Top level of the fixed-block free-list allocator: register port, output register.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_link_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per transaction:
//   allocate, free, initialize or no operation. The output channel
//   (out_valid/out_ready) returns exactly one result per operation, in order.
//   Registers num_blocks (address 0) and block_bytes (address 4) are written through
//   the cfg_ port, by the user only while the block is idle; the block does not enforce it.
// Operation flow:
//   Allocate, free and no operation go through the execute state; an allocation reads
//   the next link of the head from the link memory as it is accepted, and head and count
//   are updated as the result enters the output register, which out_ready can stall.
//   Initialize writes one link per block in a sweep over min(num_blocks, 1024) blocks.
// Reset:
//   The free list is empty and the free count is zero; the link memory is not
//   cleared and holds valid links only after initialize or free.
// Stall:
//   While out_ready is low the finished result is held, one further operation
//   may be accepted, and it then waits until the output register frees up.
module fixed_block_free_list_allocator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fbfl_pkg::OP_W-1:0]        in_opcode,
  input  logic [fbfl_pkg::IDX_W-1:0]       in_free_index,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fbfl_pkg::IDX_W-1:0]       out_block_index,
  output logic [fbfl_pkg::OFF_W-1:0]       out_block_offset,
  output logic [fbfl_pkg::STAT_W-1:0]      out_status,
  output logic [fbfl_pkg::COUNT_W-1:0]     out_free_count
);

  fbfl_pkg::cfg_t    cfg_r;
  fbfl_pkg::result_t res;
  fbfl_pkg::result_t out_r;
  logic              out_valid_r;
  logic              res_valid;
  logic              res_ready;
  logic              cfg_wr;

  logic                          ram_we;
  logic [fbfl_pkg::IDX_W-1:0]    ram_waddr;
  fbfl_pkg::link_t               ram_wdata;
  logic                          ram_re;
  logic [fbfl_pkg::IDX_W-1:0]    ram_raddr;
  fbfl_pkg::link_t               ram_rdata;

  // Register writes complete in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_blocks  <= fbfl_pkg::NUM_W'(1024);
      cfg_r.block_bytes <= fbfl_pkg::BYTES_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        fbfl_pkg::REG_NUM_BLOCKS:  cfg_r.num_blocks  <= cfg_pwdata[fbfl_pkg::NUM_W-1:0];
        fbfl_pkg::REG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_pwdata[fbfl_pkg::BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_paddr[2])
      fbfl_pkg::REG_NUM_BLOCKS:  cfg_prdata = 32'(cfg_r.num_blocks);
      fbfl_pkg::REG_BLOCK_BYTES: cfg_prdata = 32'(cfg_r.block_bytes);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Sequencer.
  fbfl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_free_index(in_free_index),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // Next-link memory.
  fbfl_link_ram #(
    .DEPTH(fbfl_pkg::MAX_BLOCKS),
    .WIDTH(fbfl_pkg::LINK_W)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register; it loads whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_index  = out_r.block_index;
  assign out_block_offset = out_r.block_offset;
  assign out_status       = out_r.status;
  assign out_free_count   = out_r.free_count;

endmodule

@@ hw/rtl/fbfl_link_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while no read is issued; no dependencies.
module fbfl_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/fbfl_ctrl.sv @@
// Free-list sequencer: head pointer, free count, init sweep and result build.
// Depends on fbfl_pkg; drives the link memory in fbfl_link_ram.
module fbfl_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fbfl_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fbfl_pkg::OP_W-1:0]     in_opcode,
  input  logic [fbfl_pkg::IDX_W-1:0]    in_free_index,
  output logic                          res_valid,
  input  logic                          res_ready,
  output fbfl_pkg::result_t             res,
  output logic                          ram_we,
  output logic [fbfl_pkg::IDX_W-1:0]    ram_waddr,
  output fbfl_pkg::link_t               ram_wdata,
  output logic                          ram_re,
  output logic [fbfl_pkg::IDX_W-1:0]    ram_raddr,
  input  fbfl_pkg::link_t               ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_INIT_DONE
  } state_t;

  state_t                          state_r;
  logic [fbfl_pkg::OP_W-1:0]       op_r;
  logic [fbfl_pkg::IDX_W-1:0]      idx_r;
  fbfl_pkg::link_t                 head_r;
  logic [fbfl_pkg::COUNT_W-1:0]    count_r;
  logic [fbfl_pkg::IDX_W-1:0]      sweep_r;

  logic [fbfl_pkg::NUM_W-1:0]      n_eff;
  logic                            accept;
  logic                            commit;
  logic                            head_empty;
  logic                            idx_ok;
  logic                            sweep_last;
  logic [fbfl_pkg::NUM_W-1:0]      sweep_inc;
  logic [fbfl_pkg::IDX_W+fbfl_pkg::BYTES_W-1:0] prod;
  logic [fbfl_pkg::COUNT_W-1:0]    count_dec;
  logic [fbfl_pkg::COUNT_W-1:0]    count_inc;

  // Block count saturated to the pool size.
  assign n_eff = (cfg.num_blocks > fbfl_pkg::NUM_W'(fbfl_pkg::MAX_BLOCKS)) ?
                 fbfl_pkg::NUM_W'(fbfl_pkg::MAX_BLOCKS) : cfg.num_blocks;

  // Handshake and commit.
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = res_valid && res_ready;

  // Operation checks and arithmetic.
  assign head_empty = (head_r >= fbfl_pkg::NIL_LINK);
  assign idx_ok     = (fbfl_pkg::NUM_W'(idx_r) < n_eff);
  assign sweep_inc  = fbfl_pkg::NUM_W'(sweep_r) + fbfl_pkg::NUM_W'(1);
  assign sweep_last = (sweep_inc >= n_eff);
  assign prod       = head_r[fbfl_pkg::IDX_W-1:0] * cfg.block_bytes;
  assign count_dec  = (count_r != '0) ? count_r - 1'b1 : count_r;
  assign count_inc  = (count_r != fbfl_pkg::COUNT_MAX) ? count_r + 1'b1 : count_r;

  // The next link of the head is read as an allocation is accepted.
  assign ram_re    = accept && (in_opcode == fbfl_pkg::OP_ALLOC);
  assign ram_raddr = head_r[fbfl_pkg::IDX_W-1:0];

  // Link writes: init sweep, or a push on a committed in-range free.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = head_r;
    if (state_r == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = sweep_last ? fbfl_pkg::NIL_LINK : fbfl_pkg::link_t'(sweep_inc);
    end else if (commit && (state_r == S_EXEC) && (op_r == fbfl_pkg::OP_FREE) && idx_ok) begin
      ram_we = 1'b1;
    end
  end

  // Result build.
  always_comb begin
    res_valid        = (state_r == S_EXEC) || (state_r == S_INIT_DONE);
    res.block_index  = '0;
    res.block_offset = '0;
    res.status       = fbfl_pkg::ST_OK;
    res.free_count   = count_r;
    if (state_r == S_INIT_DONE) begin
      res.free_count = fbfl_pkg::COUNT_W'(n_eff);
    end else begin
      case (op_r)
        fbfl_pkg::OP_ALLOC: begin
          if (head_empty) begin
            res.status = fbfl_pkg::ST_EMPTY;
          end else begin
            res.block_index  = head_r[fbfl_pkg::IDX_W-1:0];
            res.block_offset = prod[fbfl_pkg::OFF_W-1:0];
            res.free_count   = count_dec;
          end
        end
        fbfl_pkg::OP_FREE: begin
          if (idx_ok) begin
            res.free_count = count_inc;
          end else begin
            res.status = fbfl_pkg::ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer with head pointer and free count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= fbfl_pkg::NIL_LINK;
      count_r <= '0;
      op_r    <= fbfl_pkg::OP_NOP;
      idx_r   <= '0;
      sweep_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_opcode;
            idx_r   <= in_free_index;
            sweep_r <= '0;
            if (in_opcode == fbfl_pkg::OP_INIT) begin
              state_r <= (n_eff == '0) ? S_INIT_DONE : S_SWEEP;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_r <= S_IDLE;
            if ((op_r == fbfl_pkg::OP_ALLOC) && !head_empty) begin
              head_r  <= ram_rdata;
              count_r <= count_dec;
            end else if ((op_r == fbfl_pkg::OP_FREE) && idx_ok) begin
              head_r  <= fbfl_pkg::link_t'(idx_r);
              count_r <= count_inc;
            end
          end
        end
        S_SWEEP: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_last) begin
            state_r <= S_INIT_DONE;
          end
        end
        S_INIT_DONE: begin
          if (commit) begin
            state_r <= S_IDLE;
            head_r  <= (n_eff == '0) ? fbfl_pkg::NIL_LINK : '0;
            count_r <= fbfl_pkg::COUNT_W'(n_eff);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The head is always a block index or the end mark.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= fbfl_pkg::NIL_LINK)
    else $error("head pointer beyond end mark");

  // A link read and a link write never share a cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("link read overlaps link write");

  // Any operation other than init presents its result in the cycle after accept.
  a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode != fbfl_pkg::OP_INIT)) |=> res_valid)
    else $error("result not presented after accept");

  // The init sweep stays inside the effective pool.
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (fbfl_pkg::NUM_W'(sweep_r) < n_eff))
    else $error("init sweep beyond block count");

endmodule
